FILE: sv/imh_pkg.sv
// indexed_min_heap package: word types, action and status codes, sequencer states
// no dependencies

package imh_pkg;

  localparam int ID_BITS = 10;
  localparam int KEY_W = 32;
  localparam int ID_SPACE = 1024;

  typedef enum logic [2:0] {
    ACT_INSERT = 3'd0,
    ACT_POP    = 3'd1,
    ACT_REMOVE = 3'd2,
    ACT_REKEY  = 3'd3,
    ACT_PEEK   = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_FULL    = 3'd2,
    ST_ABSENT  = 3'd3,
    ST_PRESENT = 3'd4
  } status_t;

  typedef struct packed {
    logic [2:0]         action;
    logic [ID_BITS-1:0] entry_id;
    logic signed [KEY_W-1:0] key_value;
  } req_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] result_key;
    logic [ID_BITS-1:0]      result_id;
    logic [2:0]              status;
    logic [ID_BITS-1:0]      entry_count;
  } rsp_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_TAKERD,
    S_TAKELAST,
    S_TAKEGOT,
    S_UPRD,
    S_UPCMP,
    S_DNRD,
    S_DNRD2,
    S_DNCMP,
    S_PUT,
    S_DONE
  } state_t;

endpackage

FILE: sv/indexed_min_heap.sv
// indexed_min_heap top level: request sequencer, heap and position memories
// depends on imh_pkg and imh_ram
//
// An addressable min-heap of (key, id) pairs ordered by key then id. After reset the
// position memory is cleared with in_ready low. Every request is then worked through
// the heap memory one read a cycle, the moving entry held in a register: a peek, a
// refused request or an unused action goes from the check state straight to done,
// an insert climbs one level per read-and-compare pair, a pop takes the last entry and
// sinks it from the root, a remove or rekey climbs or sinks from the entry's slot.
// One request is in flight at a time; the result word waits in an output register, so
// the next word may be taken and worked while it waits, stalling only at its end.

module indexed_min_heap #(
  parameter int SLOTS = 1024,
  parameter int KEY_BITS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  imh_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output imh_pkg::rsp_t out_data
);

  localparam int SB = $clog2(SLOTS);
  localparam int KB = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int IB = imh_pkg::ID_BITS;
  localparam int EW = KEY_BITS + IB;
  localparam int RW = imh_pkg::KEY_W;

  typedef struct packed {
    logic signed [KEY_BITS-1:0] key;
    logic [IB-1:0]              id;
  } ent_t;

  imh_pkg::state_t state, state_next;

  logic [IB-1:0]        clr;
  logic [SB-1:0]        count;
  logic [2:0]           act;
  ent_t                 cur;
  ent_t                 lch;
  logic [SB-1:0]        pos;
  logic                 moved;
  logic                 at_end;
  logic signed [RW-1:0] res_key;
  logic [IB-1:0]        res_id;
  imh_pkg::status_t     res_st;
  logic                 rsp_full, rsp_full_next;
  imh_pkg::rsp_t        rsp;

  logic          h_we, p_we;
  logic [SB-1:0] h_wa, h_ra;
  ent_t          h_wd, h_rd;
  logic [EW-1:0] h_rdr;
  logic [IB-1:0] p_wa, p_ra;
  logic [SB:0]   p_wd, p_rd;

  imh_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_heap (
    .clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rdr)
  );
  assign h_rd = ent_t'(h_rdr);

  // position memory entry: presence bit above the slot
  imh_ram #(.WIDTH(SB + 1), .DEPTH(imh_pkg::ID_SPACE)) u_pos (
    .clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd)
  );

  function automatic logic gt(ent_t a, ent_t b);
    if (a.key != b.key) begin
      return a.key > b.key;
    end
    return a.id > b.id;
  endfunction

  logic signed [KEY_BITS-1:0] in_key;
  assign in_key = KEY_BITS'(signed'(in_data.key_value[KB-1:0]));

  logic [SB-1:0] up, lft, rgt;
  assign up  = pos >> 1;
  assign lft = {pos[SB-2:0], 1'b0};
  assign rgt = {pos[SB-2:0], 1'b1};
  logic lft_ok, rgt_ok;
  assign lft_ok = (pos[SB-1] == 1'b0) && (lft <= count) && (lft != '0);
  assign rgt_ok = (pos[SB-1] == 1'b0) && (rgt <= count);

  logic full, peek_ok, up_only, up_swap, dn_swap, done_go;
  assign full    = count >= SB'(SLOTS - 1);
  assign peek_ok = (act == imh_pkg::ACT_PEEK) && (count != '0);
  assign up_only = moved || (act == imh_pkg::ACT_INSERT);
  assign up_swap = gt(h_rd, cur);
  assign done_go = (state == imh_pkg::S_DONE) && (!rsp_full || out_ready);

  ent_t          best;
  logic [SB-1:0] best_pos;
  always_comb begin
    if (rgt_ok && gt(lch, h_rd)) begin
      best = h_rd;
      best_pos = rgt;
    end else begin
      best = lch;
      best_pos = lft;
    end
  end
  assign dn_swap = gt(cur, best);

  imh_pkg::status_t chk_st;
  always_comb begin
    chk_st = imh_pkg::ST_OK;
    unique case (act) inside
      imh_pkg::ACT_INSERT: begin
        if (p_rd[SB]) chk_st = imh_pkg::ST_PRESENT;
        else if (full) chk_st = imh_pkg::ST_FULL;
      end
      imh_pkg::ACT_POP, imh_pkg::ACT_PEEK: begin
        if (count == '0) chk_st = imh_pkg::ST_EMPTY;
      end
      imh_pkg::ACT_REMOVE, imh_pkg::ACT_REKEY: begin
        if (!p_rd[SB]) chk_st = imh_pkg::ST_ABSENT;
      end
      default: ;
    endcase
  end

  assign in_ready  = (state == imh_pkg::S_IDLE);
  assign out_valid = rsp_full;
  assign out_data  = rsp;

  always_comb begin
    state_next = state;
    unique case (state)
      imh_pkg::S_CLEAR: begin
        if (clr == IB'(imh_pkg::ID_SPACE - 1)) state_next = imh_pkg::S_IDLE;
      end
      imh_pkg::S_IDLE: if (in_valid && in_ready) state_next = imh_pkg::S_CHECK;
      imh_pkg::S_CHECK: begin
        if (chk_st != imh_pkg::ST_OK) begin
          state_next = imh_pkg::S_DONE;
        end else begin
          unique case (act) inside
            imh_pkg::ACT_INSERT, imh_pkg::ACT_REKEY: state_next = imh_pkg::S_UPRD;
            imh_pkg::ACT_POP, imh_pkg::ACT_REMOVE: state_next = imh_pkg::S_TAKERD;
            default: state_next = imh_pkg::S_DONE;
          endcase
        end
      end
      imh_pkg::S_TAKERD: state_next = imh_pkg::S_TAKELAST;
      imh_pkg::S_TAKELAST: state_next = imh_pkg::S_TAKEGOT;
      imh_pkg::S_TAKEGOT: state_next = at_end ? imh_pkg::S_DONE : imh_pkg::S_UPRD;
      imh_pkg::S_UPRD: begin
        if (pos != SB'(1)) state_next = imh_pkg::S_UPCMP;
        else state_next = up_only ? imh_pkg::S_PUT : imh_pkg::S_DNRD;
      end
      imh_pkg::S_UPCMP: begin
        if (up_swap) state_next = imh_pkg::S_UPRD;
        else state_next = up_only ? imh_pkg::S_PUT : imh_pkg::S_DNRD;
      end
      imh_pkg::S_DNRD: state_next = lft_ok ? imh_pkg::S_DNRD2 : imh_pkg::S_PUT;
      imh_pkg::S_DNRD2: state_next = imh_pkg::S_DNCMP;
      imh_pkg::S_DNCMP: state_next = dn_swap ? imh_pkg::S_DNRD : imh_pkg::S_PUT;
      imh_pkg::S_PUT: state_next = imh_pkg::S_DONE;
      imh_pkg::S_DONE: if (done_go) state_next = imh_pkg::S_IDLE;
      default: state_next = imh_pkg::S_IDLE;
    endcase
  end

  // memory controls: moved entries go into the hole, the held entry lands last
  always_comb begin
    h_we = 1'b0; h_wa = pos; h_wd = cur; h_ra = pos;
    p_we = 1'b0; p_wa = cur.id; p_wd = {1'b1, pos}; p_ra = in_data.entry_id;
    unique case (state)
      imh_pkg::S_CLEAR: begin
        p_we = 1'b1; p_wa = clr; p_wd = '0;
      end
      imh_pkg::S_IDLE: h_ra = SB'(1);
      imh_pkg::S_TAKELAST: begin
        h_ra = count; p_we = 1'b1; p_wa = h_rd.id; p_wd = '0;
      end
      imh_pkg::S_UPRD: h_ra = up;
      imh_pkg::S_UPCMP: begin
        if (up_swap) begin
          h_we = 1'b1; h_wd = h_rd; p_we = 1'b1; p_wa = h_rd.id;
        end
      end
      imh_pkg::S_DNRD: h_ra = lft;
      imh_pkg::S_DNRD2: h_ra = rgt;
      imh_pkg::S_DNCMP: begin
        if (dn_swap) begin
          h_we = 1'b1; h_wd = best; p_we = 1'b1; p_wa = best.id;
        end
      end
      imh_pkg::S_PUT: begin
        h_we = 1'b1; p_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    rsp_full_next = rsp_full;
    if (out_valid && out_ready) rsp_full_next = 1'b0;
    if (done_go) rsp_full_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= imh_pkg::S_CLEAR;
      clr      <= '0;
      count    <= '0;
      rsp_full <= 1'b0;
    end else begin
      state    <= state_next;
      rsp_full <= rsp_full_next;
      unique case (state)
        imh_pkg::S_CLEAR: clr <= clr + 1'b1;
        imh_pkg::S_IDLE: begin
          if (in_valid && in_ready) begin
            act <= in_data.action;
            cur <= '{key: in_key, id: in_data.entry_id};
          end
        end
        imh_pkg::S_CHECK: begin
          res_st  <= chk_st;
          res_key <= peek_ok ? RW'(h_rd.key) : '0;
          res_id  <= peek_ok ? h_rd.id : '0;
          moved   <= 1'b0;
          if (chk_st == imh_pkg::ST_OK) begin
            unique case (act) inside
              imh_pkg::ACT_INSERT: begin
                pos   <= count + 1'b1;
                count <= count + 1'b1;
              end
              imh_pkg::ACT_POP: pos <= SB'(1);
              imh_pkg::ACT_REMOVE, imh_pkg::ACT_REKEY: pos <= p_rd[SB-1:0];
              default: ;
            endcase
          end
        end
        imh_pkg::S_TAKELAST: begin
          res_key <= RW'(h_rd.key);
          res_id  <= h_rd.id;
          count   <= count - 1'b1;
          at_end  <= (pos == count);
        end
        imh_pkg::S_TAKEGOT: cur <= h_rd;
        imh_pkg::S_UPCMP: begin
          if (up_swap) begin
            pos   <= up;
            moved <= 1'b1;
          end
        end
        imh_pkg::S_DNRD2: lch <= h_rd;
        imh_pkg::S_DNCMP: if (dn_swap) pos <= best_pos;
        imh_pkg::S_DONE: begin
          if (done_go) begin
            rsp <= '{result_key: res_key, result_id: res_id, status: res_st,
                     entry_count: IB'(count)};
          end
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: sv/imh_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies

module imh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
